FILE: sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel stepper package
// Shared constants and types for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Item modes carried on the mode field of an input beat.
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Direction of travel of the current line.
    typedef struct packed {
        logic step_x_neg;
        logic step_y_neg;
        logic axes_swapped;
    } lps_dir_t;

endpackage

FILE: sv/lps_setup.sv
// ----------------------------------------------------------------------------
// Line pixel stepper setup
// Works out the step directions, the major and minor extents and the initial
// error term of a new line from its two endpoints.
// ----------------------------------------------------------------------------
module lps_setup #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output lps_pkg::lps_dir_t            dir,
    output logic        [COORD_BITS-1:0] major_ext,
    output logic        [COORD_BITS-1:0] minor_ext,
    output logic signed [COORD_BITS+2:0] err_init
);
    import lps_pkg::*;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] dx_abs;
    logic signed [COORD_BITS:0] dy_abs;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;

    always_comb
    begin
        dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        dx_abs = dx[COORD_BITS] ? -dx : dx;
        dy_abs = dy[COORD_BITS] ? -dy : dy;
        adx = dx_abs[COORD_BITS-1:0];
        ady = dy_abs[COORD_BITS-1:0];

        dir.step_x_neg   = dx[COORD_BITS];
        dir.step_y_neg   = dy[COORD_BITS];
        dir.axes_swapped = ady > adx;

        major_ext = dir.axes_swapped ? ady : adx;
        minor_ext = dir.axes_swapped ? adx : ady;

        err_init = $signed({2'b00, minor_ext, 1'b0}) - $signed({3'b000, major_ext});
    end

endmodule

FILE: sv/line_pixel_stepper_unit.sv
// ----------------------------------------------------------------------------
// Output: a pixel appears on the output in the cycle after its input beat is taken.
// Throughput: one input beat per cycle; a start or an advance beat is taken
// whenever the output register is empty or its pixel is taken in that cycle.
// Reset: rst_n clears the line-in-progress flag and the output valid flag;
// after reset the block is idle and advance beats give no pixel.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// Line pixel stepper
// Integer Bresenham line stepper for all octants. A start beat loads both
// endpoints and gives the first pixel; each advance beat gives the next one while a line is in progress.
// ----------------------------------------------------------------------------
module line_pixel_stepper_unit #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         last
);
    import lps_pkg::*;

    // Line state: the pixel last emitted and the terms for the next step.
    logic        [COORD_BITS-1:0] cur_x_reg,        cur_x_next;
    logic        [COORD_BITS-1:0] cur_y_reg,        cur_y_next;
    logic signed [COORD_BITS+2:0] err_reg,          err_next;
    logic        [COORD_BITS-1:0] major_reg,        major_next;
    logic        [COORD_BITS-1:0] minor_reg,        minor_next;
    logic        [COORD_BITS-1:0] pixels_left_reg,  pixels_left_next;
    lps_dir_t                     dir_reg,          dir_next;
    logic                         busy_reg,         busy_next;

    // Output register.
    logic                         out_valid_reg,    out_valid_next;
    logic        [COORD_BITS-1:0] pixel_x_reg,      pixel_x_next;
    logic        [COORD_BITS-1:0] pixel_y_reg,      pixel_y_next;
    logic                         last_reg,         last_next;

    lps_dir_t                     setup_dir;
    logic        [COORD_BITS-1:0] setup_major;
    logic        [COORD_BITS-1:0] setup_minor;
    logic signed [COORD_BITS+2:0] setup_err;

    logic                         accept;
    logic                         produce;
    logic                         minor_move;
    logic        [COORD_BITS-1:0] x_step;
    logic        [COORD_BITS-1:0] y_step;
    logic        [COORD_BITS-1:0] adv_x;
    logic        [COORD_BITS-1:0] adv_y;
    logic signed [COORD_BITS+2:0] major2;
    logic signed [COORD_BITS+2:0] minor2;
    logic signed [COORD_BITS+2:0] adv_err;
    logic        [COORD_BITS-1:0] left_dec;

    lps_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .dir       (setup_dir),
        .major_ext (setup_major),
        .minor_ext (setup_minor),
        .err_init  (setup_err)
    );

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign produce  = accept && ((mode == MODE_START) || busy_reg);

    always_comb
    begin
        // One Bresenham step from the pixel last emitted.
        minor_move = !err_reg[COORD_BITS+2];
        x_step = dir_reg.step_x_neg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        y_step = dir_reg.step_y_neg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        if (dir_reg.axes_swapped)
        begin
            adv_x = minor_move ? x_step : cur_x_reg;
            adv_y = y_step;
        end
        else
        begin
            adv_x = x_step;
            adv_y = minor_move ? y_step : cur_y_reg;
        end
        major2  = $signed({2'b00, major_reg, 1'b0});
        minor2  = $signed({2'b00, minor_reg, 1'b0});
        adv_err = minor_move ? err_reg + minor2 - major2 : err_reg + minor2;
        left_dec = pixels_left_reg - 1'b1;

        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        err_next         = err_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        pixels_left_next = pixels_left_reg;
        dir_next         = dir_reg;
        busy_next        = busy_reg;

        out_valid_next = out_valid_reg && out_stall;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        last_next      = last_reg;

        if (produce)
        begin
            out_valid_next = 1'b1;
            case (mode)
                MODE_START:
                begin
                    cur_x_next       = start_x;
                    cur_y_next       = start_y;
                    err_next         = setup_err;
                    major_next       = setup_major;
                    minor_next       = setup_minor;
                    pixels_left_next = setup_major;
                    dir_next         = setup_dir;
                end
                MODE_ADVANCE:
                begin
                    cur_x_next       = adv_x;
                    cur_y_next       = adv_y;
                    err_next         = adv_err;
                    pixels_left_next = left_dec;
                end
                default:
                begin
                    cur_x_next = cur_x_reg;
                end
            endcase
            pixel_x_next = cur_x_next;
            pixel_y_next = cur_y_next;
            last_next    = (pixels_left_next == '0);
            busy_next    = !last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        err_reg         <= err_next;
        major_reg       <= major_next;
        minor_reg       <= minor_next;
        pixels_left_reg <= pixels_left_next;
        dir_reg         <= dir_next;
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        last_reg        <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign last      = last_reg;

endmodule

FILE: sv/lps_checker.sv
// ----------------------------------------------------------------------------
// Line pixel stepper checker
// Port-level checks of the line pixel stepper, bound to its top level.
// ----------------------------------------------------------------------------
module lps_checker #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         mode,
    input logic signed [COORD_BITS-1:0] start_x,
    input logic signed [COORD_BITS-1:0] start_y,
    input logic signed [COORD_BITS-1:0] end_x,
    input logic signed [COORD_BITS-1:0] end_y,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [COORD_BITS-1:0] pixel_x,
    input logic signed [COORD_BITS-1:0] pixel_y,
    input logic                         last
);
    import lps_pkg::*;

    logic start_beat;

    assign start_beat = in_valid && !in_stall && (mode == MODE_START);

    // A stalled output beat holds its pixel.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(last))
        else $error("stalled output beat changed");

    // The input side is held back only by a full, stalled output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled output beat");

    // A start beat gives its start point in the next cycle.
    a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        start_beat |=> out_valid && (pixel_x == $past(start_x))
            && (pixel_y == $past(start_y)))
        else $error("first pixel is not the start point");

    // Only a line with equal endpoints ends on its first pixel.
    a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
        start_beat |=> last == ($past(start_x) == $past(end_x)
            && $past(start_y) == $past(end_y)))
        else $error("wrong last flag on first pixel");

endmodule

bind line_pixel_stepper_unit lps_checker #(.COORD_BITS(COORD_BITS)) u_lps_checker (.*);
